@@ src/lfs_pkg.sv @@
// Shared types, constants and helpers for the LED fade step sequencer.
package lfs_pkg;

  localparam int unsigned MaxSteps = 16;
  localparam int unsigned TblAw    = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int unsigned PosW     = $clog2(MaxSteps + 1);
  localparam int unsigned ColW     = 8;
  localparam int unsigned SubW     = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned DivCntW  = $clog2(ColW + 1);

  typedef logic [ColW-1:0] colour_t;

  typedef struct packed {
    colour_t         red;
    colour_t         green;
    colour_t         blue;
    logic [SubW-1:0] total;
    logic [SubW-1:0] delay;
  } step_entry_t;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_EXPIRY  = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_STEPS  = 2'd0,
    REG_REPEAT = 2'd1,
    REG_SINGLE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_DIV,
    ST_RDREQ,
    ST_FIN
  } state_e;

  // floor(sum / 3) for sum <= 3 * 255: multiply by 683 / 2048
  function automatic colour_t mean3(input logic [ColW+1:0] sum);
    logic [ColW+12:0] prod;
    prod = (ColW + 13)'(sum) * (ColW + 13)'(683);
    return prod[ColW+10:11];
  endfunction

endpackage

@@ src/lfs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lfs_div_lane.sv @@
// One colour lane: signed difference divided by substeps left, one quotient bit per cycle.
module lfs_div_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [lfs_pkg::ColW:0]      diff_i,
  input  logic [lfs_pkg::SubW-1:0]           divisor_i,
  output logic                               done_o,
  output logic signed [lfs_pkg::ColW:0]      quot_o
);

  logic [lfs_pkg::SubW-1:0]    rem_q, rem_d;
  logic [lfs_pkg::ColW-1:0]    q_q, q_d;
  logic [lfs_pkg::SubW-1:0]    div_q;
  logic [lfs_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic                        neg_q;
  logic [lfs_pkg::SubW:0]      trial;
  logic [lfs_pkg::SubW:0]      trial_sub;
  logic                        ge;
  logic [lfs_pkg::ColW:0]      mag_full;
  logic [lfs_pkg::ColW:0]      q_ext;

  assign trial     = {rem_q, q_q[lfs_pkg::ColW-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign ge        = (trial >= {1'b0, div_q});
  assign rem_d     = ge ? trial_sub[lfs_pkg::SubW-1:0] : trial[lfs_pkg::SubW-1:0];
  assign q_d       = {q_q[lfs_pkg::ColW-2:0], ge};

  // magnitude always fits in ColW bits since levels are unsigned ColW-bit values
  assign mag_full = diff_i[lfs_pkg::ColW] ? (-diff_i) : diff_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == lfs_pkg::DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= lfs_pkg::DivCntW'(lfs_pkg::ColW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - lfs_pkg::DivCntW'(1);
        if (cnt_q == lfs_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      q_q   <= mag_full[lfs_pkg::ColW-1:0];
      div_q <= divisor_i;
      neg_q <= diff_i[lfs_pkg::ColW];
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign q_ext  = {1'b0, q_q};
  assign quot_o = neg_q ? $signed(-q_ext) : $signed(q_ext);
  assign done_o = done_q;

endmodule

@@ src/led_effect_fade_sequencer.sv @@
// Top level of the LED fade step sequencer: control, step table and output stage.
// Each accepted item yields one result. Load, restart and other items pass through
// one read of the step table, for the delay of the current step; a timer expiry while
// armed within the steps in use passes a table read of the current step, a setup
// state, the three serial divider lanes (one quotient bit per cycle, 8 bits) and a
// second table read for the delay at the step position after the substep advance.
// The next item is taken the cycle after the result enters the output register; a
// result that waits there stalls the sequencer only when the next result is ready.
// The step table holds no reset value and must be loaded before an effect is started.
module led_effect_fade_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  entry_index_i,
  input  logic [7:0]  target_red_i,
  input  logic [7:0]  target_green_i,
  input  logic [7:0]  target_blue_i,
  input  logic [15:0] substep_total_i,
  input  logic [15:0] substep_delay_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_level_o,
  output logic [7:0]  green_level_o,
  output logic [7:0]  blue_level_o,
  output logic [7:0]  mono_level_o,
  output logic [15:0] next_delay_o,
  output logic        timer_armed_o,
  output logic        effect_done_o
);

  localparam int unsigned NumCh = 3;

  // configuration
  logic [lfs_pkg::CountW-1:0] steps_in_use_q;
  logic                       repeat_q;
  logic                       single_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_in_use_q <= '0;
      repeat_q       <= 1'b0;
      single_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfs_pkg::REG_STEPS:  steps_in_use_q <= cfg_wdata_i;
        lfs_pkg::REG_REPEAT: repeat_q       <= cfg_wdata_i[0];
        lfs_pkg::REG_SINGLE: single_q       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [lfs_pkg::PosW-1:0] count;
  assign count = (32'(steps_in_use_q) > lfs_pkg::MaxSteps) ?
                 lfs_pkg::PosW'(lfs_pkg::MaxSteps) : lfs_pkg::PosW'(steps_in_use_q);

  // sequencer state
  lfs_pkg::state_e          state_q, state_d;
  lfs_pkg::colour_t         cur_q [NumCh];
  logic [lfs_pkg::PosW-1:0] step_q;
  logic [lfs_pkg::SubW-1:0] sub_q;
  logic                     armed_q;
  logic                     done_q;
  logic [lfs_pkg::SubW-1:0] total_q;

  lfs_pkg::action_e act;
  logic             in_xfer;
  logic             step_lt_count;
  logic             idx_ok;

  assign act           = lfs_pkg::action_e'(action_i);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign step_lt_count = (step_q < count);
  assign idx_ok        = (32'(entry_index_i) < lfs_pkg::MaxSteps);

  // step table
  logic                      ram_we;
  logic                      ram_re;
  logic [lfs_pkg::TblAw-1:0] ram_raddr;
  lfs_pkg::step_entry_t      ram_wdata;
  lfs_pkg::step_entry_t      ram_rdata;

  assign ram_wdata = '{red:   target_red_i,
                       green: target_green_i,
                       blue:  target_blue_i,
                       total: substep_total_i,
                       delay: substep_delay_i};
  assign ram_raddr = step_q[lfs_pkg::TblAw-1:0];

  lfs_ram #(
    .Width ($bits(lfs_pkg::step_entry_t)),
    .Depth (lfs_pkg::MaxSteps)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lfs_pkg::TblAw'(entry_index_i)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divider lanes
  logic                          div_start;
  logic [NumCh-1:0]              div_done;
  logic signed [lfs_pkg::ColW:0] diff [NumCh];
  logic signed [lfs_pkg::ColW:0] quot [NumCh];
  lfs_pkg::colour_t              tgt  [NumCh];
  logic [lfs_pkg::SubW-1:0]      total_eff;
  logic [lfs_pkg::SubW-1:0]      left;

  assign tgt[0]    = ram_rdata.red;
  assign tgt[1]    = ram_rdata.green;
  assign tgt[2]    = ram_rdata.blue;
  assign total_eff = (ram_rdata.total == '0) ? lfs_pkg::SubW'(1) : ram_rdata.total;
  assign left      = (sub_q < total_eff) ? (total_eff - sub_q) : lfs_pkg::SubW'(1);

  for (genvar g = 0; g < NumCh; g++) begin : g_lane
    assign diff[g] = $signed({1'b0, tgt[g]}) - $signed({1'b0, cur_q[g]});

    lfs_div_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (div_start),
      .diff_i    (diff[g]),
      .divisor_i (left),
      .done_o    (div_done[g]),
      .quot_o    (quot[g])
    );
  end

  // next step position after the last substep
  logic [lfs_pkg::SubW:0]   sub_inc;
  logic                     step_end;
  logic [lfs_pkg::PosW-1:0] step_inc;
  logic                     wrap;

  assign sub_inc  = {1'b0, sub_q} + (lfs_pkg::SubW + 1)'(1);
  assign step_end = (sub_inc >= {1'b0, total_q});
  assign step_inc = step_q + lfs_pkg::PosW'(1);
  assign wrap     = (step_inc == count);

  // control
  logic out_load;
  logic out_valid_q;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      lfs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (act == lfs_pkg::ACT_EXPIRY && armed_q && step_lt_count) begin
            ram_re  = 1'b1;
            state_d = lfs_pkg::ST_ENTRY;
          end else begin
            state_d = lfs_pkg::ST_RDREQ;
          end
          if (act == lfs_pkg::ACT_LOAD && idx_ok) begin
            ram_we = 1'b1;
          end
        end
      end
      lfs_pkg::ST_ENTRY: begin
        div_start = 1'b1;
        state_d   = lfs_pkg::ST_DIV;
      end
      lfs_pkg::ST_DIV: begin
        if (div_done[0]) begin
          state_d = lfs_pkg::ST_RDREQ;
        end
      end
      lfs_pkg::ST_RDREQ: begin
        ram_re  = 1'b1;
        state_d = lfs_pkg::ST_FIN;
      end
      lfs_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = lfs_pkg::ST_IDLE;
        end
      end
      default: state_d = lfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // positions, colour and timer status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        cur_q[i] <= '0;
      end
      step_q  <= '0;
      sub_q   <= '0;
      armed_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        done_q <= 1'b0;
        case (act)
          lfs_pkg::ACT_RESTART: begin
            step_q  <= '0;
            sub_q   <= '0;
            armed_q <= (count != '0);
          end
          lfs_pkg::ACT_EXPIRY: begin
            if (armed_q && !step_lt_count) begin
              armed_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (state_q == lfs_pkg::ST_DIV && div_done[0]) begin
        for (int i = 0; i < NumCh; i++) begin
          cur_q[i] <= lfs_pkg::ColW'($signed({1'b0, cur_q[i]}) + quot[i]);
        end
        if (step_end) begin
          sub_q <= '0;
          if (wrap) begin
            step_q  <= repeat_q ? '0 : step_inc;
            done_q  <= !repeat_q;
            armed_q <= repeat_q;
          end else begin
            step_q  <= step_inc;
            armed_q <= (step_inc < count);
          end
        end else begin
          sub_q   <= sub_inc[lfs_pkg::SubW-1:0];
          armed_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lfs_pkg::ST_ENTRY) begin
      total_q <= total_eff;
    end
  end

  // output register
  logic                     armed_out;
  logic [lfs_pkg::ColW+1:0] sum3;
  lfs_pkg::colour_t         red_q, green_q, blue_q, mono_q;
  logic [lfs_pkg::SubW-1:0] delay_q;
  logic                     armed_o_q;
  logic                     done_o_q;

  assign armed_out = armed_q && (32'(step_q) < lfs_pkg::MaxSteps);
  assign sum3      = (lfs_pkg::ColW + 2)'(cur_q[0]) + (lfs_pkg::ColW + 2)'(cur_q[1]) +
                     (lfs_pkg::ColW + 2)'(cur_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q     <= single_q ? '0 : cur_q[0];
      green_q   <= single_q ? '0 : cur_q[1];
      blue_q    <= single_q ? '0 : cur_q[2];
      mono_q    <= single_q ? lfs_pkg::mean3(sum3) : '0;
      delay_q   <= armed_out ? ram_rdata.delay : '0;
      armed_o_q <= armed_out;
      done_o_q  <= done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;
  assign mono_level_o  = mono_q;
  assign next_delay_o  = delay_q;
  assign timer_armed_o = armed_o_q;
  assign effect_done_o = done_o_q;

  // assertions
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done[0] == div_done[1]) && (div_done[0] == div_done[2]))
    else $error("divider lanes out of step");

  a_armed_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q && state_q == lfs_pkg::ST_IDLE |-> 32'(step_q) < lfs_pkg::MaxSteps)
    else $error("armed with step position beyond the table");

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(effect_done_o && timer_armed_o))
    else $error("effect done while timer still armed");

  a_delay_when_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !timer_armed_o |-> next_delay_o == '0)
    else $error("nonzero delay reported while disarmed");

  a_drive_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mono_level_o != '0 |->
      red_level_o == '0 && green_level_o == '0 && blue_level_o == '0)
    else $error("colour and mono drive both active");

endmodule
